@@ rtl/lvp_pkg.sv @@
`default_nettype none
package lvp_pkg;

	localparam int STACK_DEPTH_DEF = 1024;
	localparam int MAX_POS_DEF     = 65536;

	localparam logic [7:0] CHAR_OPEN  = 8'd40;
	localparam logic [7:0] CHAR_CLOSE = 8'd41;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam int LEN_W   = 16;
	localparam int START_W = 17;
	localparam int OUT_W   = 40;

endpackage
`default_nettype wire

@@ rtl/longest_valid_parentheses.sv @@
`default_nettype none
// Longest well-matched parentheses run. Characters arrive one beat per cycle (tuser = 0) and an
// end beat (tuser = 1) yields one result beat; the block then starts over on a fresh string.
// Only '(' and ')' take positions. Open positions live in a stack memory of STACK_DEPTH
// entries; a push writes the new top, a pop reads the entry that becomes the new top, and that
// registered memory read is why the run is measured in a second stage. The sustained rate is
// one beat per cycle while no result holds the input; the end beat passes through the second
// stage into the output register. While a result waits in the output register, a following end
// beat that has reached the second stage holds the input until the result is taken. No clearing
// pass is needed after reset: stack entries above the fill count are never read.
module longest_valid_parentheses
	import lvp_pkg::*;
#(
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
	parameter int MAX_POSITIONS = MAX_POS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,  // char_code[7:0]
	input  wire logic [0:0]        s_tuser,  // command[0]
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata   // longest_length[15:0], start_index[32:16],
	                                         // overflow[33], zero fill[39:34]
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int CW = $clog2(MAX_POSITIONS + 1);
	localparam int XW = (CW > START_W) ? CW : START_W;

	localparam logic [DW-1:0] DEPTH_C = DW'(STACK_DEPTH);
	localparam logic [CW-1:0] MAXP_C  = CW'(MAX_POSITIONS);

	// positions are kept one-based: a run starting after base b has start b and length n - b
	logic [CW-1:0] open_mem [STACK_DEPTH];
	logic [CW-1:0] rd_q;

	logic [DW-1:0] count_q;
	logic [CW-1:0] npos_q;
	logic [CW-1:0] bar_q;
	logic          ovf_q;
	logic          any_q;

	logic          v_s1, end_s1, pop_s1, frombar_s1, ovf_s1, any_s1;
	logic [CW-1:0] n_s1, bar_s1;

	logic [CW-1:0] best_q, bst_q;

	logic          stall, acc, is_end, is_open, is_close, pos_full, do_push, do_pop;
	logic [CW-1:0] n_new;

	assign stall    = v_s1 && end_s1 && m_tvalid && !m_tready;
	assign s_tready = !stall;
	assign acc      = s_tvalid && s_tready;

	assign is_end   = (s_tuser[0] == CMD_END);
	assign is_open  = (s_tdata == CHAR_OPEN);
	assign is_close = (s_tdata == CHAR_CLOSE);
	assign pos_full = (npos_q == MAXP_C);
	assign n_new    = npos_q + CW'(1);
	assign do_push  = acc && !is_end && is_open && !pos_full && (count_q != DEPTH_C);
	assign do_pop   = acc && !is_end && is_close && !pos_full && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			open_mem[count_q[AW-1:0]] <= n_new;
		end
		if (do_pop && count_q > DW'(1)) begin
			rd_q <= open_mem[AW'(count_q - DW'(2))];
		end
	end

	// front stage: position counter, stack pointer, barrier, flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			npos_q  <= '0;
			bar_q   <= '0;
			ovf_q   <= 1'b0;
			any_q   <= 1'b0;
		end else if (acc) begin
			if (is_end) begin
				count_q <= '0;
				npos_q  <= '0;
				bar_q   <= '0;
				ovf_q   <= 1'b0;
				any_q   <= 1'b0;
			end else begin
				any_q <= 1'b1;
				if (is_open || is_close) begin
					if (pos_full) begin
						ovf_q <= 1'b1;
					end else begin
						npos_q <= n_new;
						if (is_open) begin
							if (count_q == DEPTH_C) begin
								ovf_q <= 1'b1;
							end else begin
								count_q <= count_q + DW'(1);
							end
						end else if (count_q == '0) begin
							bar_q <= n_new;
						end else begin
							count_q <= count_q - DW'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= acc && (is_end || do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			end_s1     <= is_end;
			pop_s1     <= do_pop;
			frombar_s1 <= (count_q == DW'(1));
			n_s1       <= n_new;
			bar_s1     <= bar_q;
			ovf_s1     <= ovf_q;
			any_s1     <= any_q;
		end
	end

	// second stage: measure the closed run, keep the earliest longest
	logic [CW-1:0] base, run_len;
	assign base    = frombar_s1 ? bar_s1 : rd_q;
	assign run_len = n_s1 - base;

	logic [XW-1:0] best_x, bst_x;
	logic          clamp;
	assign best_x = XW'(best_q);
	assign bst_x  = XW'(bst_q);
	assign clamp  = best_x > XW'(17'h0FFFF);

	logic [LEN_W-1:0]   len_out;
	logic [START_W-1:0] start_out;
	always_comb begin
		len_out = clamp ? LEN_W'(16'hFFFF) : best_x[LEN_W-1:0];
		if (best_q == '0) begin
			start_out = any_s1 ? '1 : '0;
		end else begin
			start_out = bst_x[START_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (v_s1 && !stall) begin
			if (end_s1) begin
				best_q <= '0;
			end else if (pop_s1 && run_len > best_q) begin
				best_q <= run_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && !stall && !end_s1 && pop_s1 && run_len > best_q) begin
			bst_q <= base;
		end
	end

	// the output register reloads in the same cycle its beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (v_s1 && end_s1 && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && end_s1 && (!m_tvalid || m_tready)) begin
			m_tdata <= {(OUT_W - LEN_W - START_W - 1)'(0), ovf_s1 || clamp, start_out, len_out};
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/longest_valid_parentheses_tb.sv @@
`timescale 1ns / 100ps
module longest_valid_parentheses_tb;
	import lvp_pkg::*;

	typedef struct packed {
		logic             ovf;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0] len;
	} result_t;

	// one row sends code reps times; paired rows send "()" reps times
	typedef struct {
		logic       cmd;
		logic [7:0] code;
		int         reps;
		bit         paired;
		bit         typed;
		result_t    res;
	} stim_row_t;

	localparam int N_ROWS = 27;
	localparam logic [START_W-1:0] NO_RUN = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = 8'd0;   // char_code[7:0]
	logic [0:0]        s_tuser = 1'b0;   // command[0]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;          // longest_length[15:0], start_index[32:16],
	                                     // overflow[33], zero fill[39:34]

	// predictor state
	logic [15:0] open_pos [STACK_DEPTH_DEF];
	int          open_cnt;
	int          brk_pos;
	int          barrier;
	int          best_len;
	int          best_st;
	bit          seen_any;
	bit          seen_ovf;

	result_t pending_results [$];
	int      err_cnt = 0;
	int      results_seen = 0;
	int      beats_sent = 0;
	int      strings_sent = 0;
	bit      idle_on = 1'b0;
	int      stall_left = 0;

	stim_row_t dir_tab [N_ROWS] = '{
		'{CMD_END,  8'h00,      1,     0, 1, '{1'b0, 17'd0, 16'd0}},
		'{CMD_END,  8'h00,      1,     0, 1, '{1'b0, 17'd0, 16'd0}},
		'{CMD_CHAR, 8'd65,      1,     0, 0, '0},
		'{CMD_END,  8'h00,      1,     0, 1, '{1'b0, NO_RUN, 16'd0}},
		'{CMD_CHAR, CHAR_OPEN,  1,     0, 0, '0},
		'{CMD_CHAR, CHAR_CLOSE, 1,     0, 0, '0},
		'{CMD_END,  8'h00,      1,     0, 1, '{1'b0, 17'd0, 16'd2}},
		'{CMD_CHAR, CHAR_CLOSE, 1,     0, 0, '0},
		'{CMD_CHAR, CHAR_OPEN,  1,     0, 0, '0},
		'{CMD_CHAR, CHAR_CLOSE, 1,     0, 0, '0},
		'{CMD_CHAR, CHAR_OPEN,  1,     0, 0, '0},
		'{CMD_CHAR, CHAR_CLOSE, 1,     0, 0, '0},
		'{CMD_CHAR, CHAR_CLOSE, 1,     0, 0, '0},
		'{CMD_END,  8'h00,      1,     0, 1, '{1'b0, 17'd1, 16'd4}},
		// quote and extreme bytes inside a match are skipped
		'{CMD_CHAR, CHAR_OPEN,  1,     0, 0, '0},
		'{CMD_CHAR, 8'd34,      1,     0, 0, '0},
		'{CMD_CHAR, 8'h00,      1,     0, 0, '0},
		'{CMD_CHAR, 8'hff,      1,     0, 0, '0},
		'{CMD_CHAR, CHAR_CLOSE, 1,     0, 0, '0},
		'{CMD_END,  8'hff,      1,     0, 0, '0},
		// two equal runs split by a barrier, earliest wins
		'{CMD_CHAR, 8'h00,      1,     1, 0, '0},
		'{CMD_CHAR, CHAR_CLOSE, 1,     0, 0, '0},
		'{CMD_CHAR, 8'h00,      1,     1, 0, '0},
		'{CMD_END,  8'h00,      1,     0, 0, '0},
		// stack full
		'{CMD_CHAR, CHAR_OPEN,  1025,  0, 0, '0},
		'{CMD_CHAR, CHAR_CLOSE, 3,     0, 0, '0},
		'{CMD_END,  8'h00,      1,     0, 0, '0}
	};

	longest_valid_parentheses u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_matcher();
		open_cnt = 0;
		brk_pos  = -1;
		barrier  = -1;
		best_len = 0;
		best_st  = -1;
		seen_any = 1'b0;
		seen_ovf = 1'b0;
	endfunction

	function automatic void feed_char(logic [7:0] code);
		int len;
		seen_any = 1'b1;
		if (code != CHAR_OPEN && code != CHAR_CLOSE)
			return;
		if (brk_pos + 1 >= MAX_POS_DEF) begin
			seen_ovf = 1'b1;
			return;
		end
		brk_pos++;
		if (code == CHAR_OPEN) begin
			// a full stack still uses up the position
			if (open_cnt >= STACK_DEPTH_DEF) begin
				seen_ovf = 1'b1;
				return;
			end
			open_pos[open_cnt] = brk_pos[15:0];
			open_cnt++;
			return;
		end
		if (open_cnt == 0) begin
			barrier = brk_pos;
			return;
		end
		open_cnt--;
		if (open_cnt == 0)
			len = brk_pos - barrier;
		else
			len = brk_pos - int'({16'd0, open_pos[open_cnt-1]});
		if (len > best_len) begin
			best_len = len;
			best_st  = brk_pos - len + 1;
		end
	endfunction

	function automatic result_t close_string();
		result_t r;
		int      st;
		r.len = (best_len > 65535) ? 16'hffff : best_len[15:0];
		r.ovf = seen_ovf || (best_len > 65535);
		if (best_len == 0)
			st = seen_any ? -1 : 0;
		else
			st = best_st;
		r.start = st[START_W-1:0];
		clear_matcher();
		return r;
	endfunction

	task automatic push_beat(input logic cmd, input logic [7:0] code,
			input bit fixed = 1'b0, input result_t fixed_res = '0);
		int      gap;
		result_t r;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= code;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
		if (cmd == CMD_CHAR) begin
			feed_char(code);
		end else begin
			r = close_string();
			if (fixed)
				r = fixed_res;
			pending_results.push_back(r);
			strings_sent++;
		end
	endtask

	task automatic send_random_string();
		int         mode;
		int         n;
		int         depth;
		int         pick;
		int         i;
		logic [7:0] code;
		mode = $urandom_range(0, 9);
		if (mode == 9)
			n = 0;
		else if ($urandom_range(0, 15) == 0)
			n = $urandom_range(40, 300);
		else
			n = $urandom_range(1, 24);
		depth = 0;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			// modes below 6 mostly build nested runs, 6 and 7 are mixed, 8 is raw bytes
			if (mode == 8 || (mode >= 6 && pick < 50) || pick < 8)
				code = 8'($urandom_range(0, 255));
			else if (mode >= 6)
				code = (pick < 75) ? CHAR_OPEN : CHAR_CLOSE;
			else if (depth == 0)
				code = (pick < 85) ? CHAR_OPEN : CHAR_CLOSE;
			else
				code = (pick < 54) ? CHAR_OPEN : CHAR_CLOSE;
			if (code == CHAR_OPEN)
				depth++;
			else if (code == CHAR_CLOSE && depth > 0)
				depth--;
			push_beat(CMD_CHAR, code);
		end
		push_beat(CMD_END, 8'($urandom));
	endtask

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (!idle_on) begin
			m_tready   <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[LEN_W+START_W:0]);
			results_seen++;
			if (pending_results.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result beat: len=%0d start=%h ovf=%0b",
						got.len, got.start, got.ovf);
			end else begin
				want = pending_results.pop_front();
				if (got.len !== want.len || got.start !== want.start ||
						got.ovf !== want.ovf) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch on string %0d: exp len=%0d start=%h ovf=%0b, got len=%0d start=%h ovf=%0b",
							results_seen, want.len, want.start, want.ovf,
							got.len, got.start, got.ovf);
				end
			end
		end
	end

	initial begin
		#(40_000_000);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int i;
		int k;
		clear_matcher();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_ROWS; i++) begin
			idle_on = (dir_tab[i].reps <= 100);
			for (k = 0; k < dir_tab[i].reps; k++) begin
				if (dir_tab[i].paired) begin
					push_beat(CMD_CHAR, CHAR_OPEN);
					push_beat(CMD_CHAR, CHAR_CLOSE);
				end else begin
					push_beat(dir_tab[i].cmd, dir_tab[i].code, dir_tab[i].typed,
						dir_tab[i].res);
				end
			end
		end

		// the last stretch, from 1650 beats on, runs with no idling on either side
		while (beats_sent < 1950) begin
			idle_on = (beats_sent < 1650) && ($urandom_range(0, 3) != 0);
			send_random_string();
		end
		s_tvalid <= 1'b0;

		k = 0;
		while (pending_results.size() != 0 && k < 20000) begin
			@(posedge clk);
			k++;
		end
		if (pending_results.size() != 0) begin
			err_cnt++;
			$display("%0d results never arrived", pending_results.size());
		end
		repeat (16) @(posedge clk);

		$display("covered %0d strings in %0d beats, %0d results compared, %0d errors",
			strings_sent, beats_sent, results_seen, err_cnt);
		$display("incl. empty strings, barriers, ties, stray bytes, stack full, stalls");
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ longest_valid_parentheses.f @@
rtl/lvp_pkg.sv
rtl/longest_valid_parentheses.sv
tb/sv/longest_valid_parentheses_tb.sv
